/* hw/rtl/b64d_pkg.sv */
// b64d_pkg: types, constants and the character classifier for the Base64 decoder.
// Used by the front, queue, back and top-level RTL files; depends on nothing.
`timescale 1ns / 1ps

package b64d_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Register map (word index taken from paddr[2]).
  localparam logic REG_OUT_LIMIT = 1'b0;

  localparam logic [15:0] OUT_LIMIT_RESET = 16'hFFFF;
  localparam int unsigned MAX_TEXT_LEN    = 32'd65535;
  localparam logic [15:0] POS_SAT         = 16'hFFFF;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CODE_SKIP  = 8'd254;
  localparam logic [7:0] CODE_BAD   = 8'd255;
  localparam logic [7:0] CODE_PLUS  = 8'd62;
  localparam logic [7:0] CODE_SLASH = 8'd63;

  // One queued transaction group: the bytes and optional status one character causes.
  typedef struct packed {
    logic [1:0]      nbytes;      // 0..3 decoded bytes
    logic [2:0][7:0] bytes;       // bytes[0] goes out first
    logic            has_status;  // end of text: status follows the bytes
    kind_t           status_kind;
    logic [15:0]     status_value;
  } entry_t;

  // Map a raw character onto its sextet, or onto CODE_SKIP / CODE_BAD.
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    if (c <= 8'd32)                    d = CODE_SKIP;
    else if (c >= "A" && c <= "Z")     d = c - 8'd65;
    else if (c >= "a" && c <= "z")     d = c - 8'd71;
    else if (c >= "0" && c <= "9")     d = c + 8'd4;
    else if (c == "+" || c == "-")     d = CODE_PLUS;
    else if (c == "/" || c == "_")     d = CODE_SLASH;
    else                               d = CODE_BAD;
    return d;
  endfunction

endpackage

/* hw/rtl/b64d_in_if.sv */
// b64d_in_if: input channel, one encoded character per transaction.
// Plain valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, char_in, end_of_text, input ready);
  modport sink   (input valid, char_in, end_of_text, output ready);
endinterface

/* hw/rtl/b64d_out_if.sv */
// b64d_out_if: result channel, one decoded byte or status per transaction.
// Plain valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] value;
  logic        last_of_run;

  modport source (output valid, kind, value, last_of_run, input ready);
  modport sink   (input valid, kind, value, last_of_run, output ready);
endinterface

/* hw/rtl/b64d_front.sv */
// b64d_front: classifies each accepted character, updates the decode state and
// builds one queue entry per character that causes results. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_in,
  input  logic                end_of_text,
  input  logic [15:0]         out_limit,
  output logic                push,
  output b64d_pkg::entry_t    entry
);

  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] char_position, char_position_next;
  logic [15:0] bytes_out, bytes_out_next;
  logic [15:0] bad_position, bad_position_next;
  logic [15:0] pad_position, pad_position_next;
  logic        halted, halted_next;

  logic [7:0]  sextet;
  logic        halt_in;
  logic [15:0] avail;
  logic [1:0]  nb;
  logic [2:0][7:0] bytes;
  logic [23:0] word;

  assign sextet = b64d_pkg::sextet_of(char_in);
  assign avail  = out_limit - bytes_out;
  assign word   = {group_bits, sextet[5:0]};

  always_comb begin
    char_position_next = char_position;
    if ({16'd0, char_position} < b64d_pkg::MAX_TEXT_LEN && char_position != b64d_pkg::POS_SAT)
      char_position_next = char_position + 16'd1;

    halt_in           = halted || (bytes_out >= out_limit);
    group_bits_next   = group_bits;
    digit_count_next  = digit_count;
    bad_position_next = bad_position;
    pad_position_next = pad_position;
    halted_next       = halt_in;
    nb                = 2'd0;
    bytes             = '0;

    if (!halt_in) begin
      if (char_in == b64d_pkg::CHAR_PAD) begin
        pad_position_next = char_position_next;
      end else if (sextet == b64d_pkg::CODE_BAD) begin
        bad_position_next = char_position_next;
        pad_position_next = '0;
      end else if (sextet != b64d_pkg::CODE_SKIP) begin
        // a digit after a pending pad turns the pad into the error
        if (pad_position != '0) begin
          bad_position_next = pad_position;
          pad_position_next = '0;
        end
        if (digit_count == 2'd3) begin
          group_bits_next  = '0;
          digit_count_next = 2'd0;
          bytes            = {word[7:0], word[15:8], word[23:16]};
          nb               = (avail >= 16'd3) ? 2'd3 : avail[1:0];
          halted_next      = (bad_position_next != '0) || ({14'd0, nb} >= avail);
        end else begin
          group_bits_next  = {group_bits[11:0], sextet[5:0]};
          digit_count_next = digit_count + 2'd1;
        end
      end
    end

    // flush a partial group; no group completed here, so avail still holds
    if (end_of_text && !halted_next && digit_count_next != 2'd0) begin
      case (digit_count_next)
        2'd1:    bytes[0] = {group_bits_next[5:0], 2'b00};
        2'd2:    bytes[0] = group_bits_next[11:4];
        default: begin
          bytes[0] = group_bits_next[17:10];
          bytes[1] = group_bits_next[9:2];
        end
      endcase
      if (digit_count_next == 2'd3 && avail >= 16'd2) nb = 2'd2;
      else if (avail != '0)                           nb = 2'd1;
      else                                            nb = 2'd0;
    end

    bytes_out_next = bytes_out + {14'd0, nb};
  end

  always_comb begin
    push               = accept && (nb != 2'd0 || end_of_text);
    entry.nbytes       = nb;
    entry.bytes        = bytes;
    entry.has_status   = end_of_text;
    if (bad_position_next != '0) begin
      entry.status_kind  = b64d_pkg::KIND_ERROR;
      entry.status_value = bad_position_next;
    end else begin
      entry.status_kind  = b64d_pkg::KIND_COUNT;
      entry.status_value = bytes_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_text)) begin
      group_bits    <= '0;
      digit_count   <= '0;
      char_position <= '0;
      bytes_out     <= '0;
      bad_position  <= '0;
      pad_position  <= '0;
      halted        <= 1'b0;
    end else if (accept) begin
      group_bits    <= group_bits_next;
      digit_count   <= digit_count_next;
      char_position <= char_position_next;
      bytes_out     <= bytes_out_next;
      bad_position  <= bad_position_next;
      pad_position  <= pad_position_next;
      halted        <= halted_next;
    end
  end

endmodule

/* hw/rtl/b64d_queue.sv */
// b64d_queue: small flop queue of entries between the front and back parts.
// Depends on b64d_pkg for the entry type.
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::entry_t wdata,
  input  logic             pop,
  output b64d_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_pkg::entry_t store [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not advance on push");

endmodule

/* hw/rtl/b64d_back.sv */
// b64d_back: unpacks queue entries into single result transactions through an
// output register. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  b64d_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_value,
  output logic             out_last
);

  logic [1:0]  idx;
  logic        load;
  logic        cur_last;
  logic [1:0]  cur_kind;
  logic [15:0] cur_value;
  logic [7:0]  cur_byte;

  always_comb begin
    case (idx)
      2'd0:    cur_byte = head.bytes[0];
      2'd1:    cur_byte = head.bytes[1];
      default: cur_byte = head.bytes[2];
    endcase
    if (idx < head.nbytes) begin
      cur_kind  = b64d_pkg::KIND_BYTE;
      cur_value = {8'd0, cur_byte};
      cur_last  = !head.has_status && (idx == head.nbytes - 2'd1);
    end else begin
      cur_kind  = head.status_kind;
      cur_value = head.status_value;
      cur_last  = 1'b1;
    end
  end

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= cur_last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= cur_kind;
      out_value <= cur_value;
      out_last  <= cur_last;
    end
  end

endmodule

/* hw/rtl/base64_lenient_decoder_unit.sv */
// base64_lenient_decoder_unit: top level of the lenient Base64 decoder.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue, b64d_back.
`timescale 1ns / 1ps

// Decodes a Base64 text fed one character per transaction, accepting the
// standard and URL-safe alphabets together and skipping control characters
// and space. A text streams in at one character per clock; as a character
// is taken, the front part updates the decode state and queues the bytes
// and status the character causes. The back part sends one result per cycle
// through an output register while the sink is ready; a character that
// completes a group yields three byte results and the end of text one more.
// Input stalls only when the QUEUE_DEPTH-entry queue fills, which at the
// Base64 ratio of three bytes per four characters does not happen while the
// sink takes every cycle. The last result of each character carries
// last_of_run. The end-of-text character always closes the text with either
// the byte count or the 1-based position of the error, then the decoder is
// ready for the next text. out_limit (APB address 0) caps the bytes per text
// and must be written only while the block is idle.

module base64_lenient_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     din,
  b64d_out_if.source  dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]      out_limit;
  logic             cfg_write;
  logic             accept;
  logic             push, pop, full, empty;
  b64d_pkg::entry_t push_entry, head_entry;

  // APB register: write on the access phase, read back the same word.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == b64d_pkg::REG_OUT_LIMIT) ? {16'd0, out_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= b64d_pkg::OUT_LIMIT_RESET;
    end else if (cfg_write && paddr[2] == b64d_pkg::REG_OUT_LIMIT) begin
      out_limit <= pwdata[15:0];
    end
  end

  // Take a character whenever the queue has room for what it may cause.
  assign din.ready = !full;
  assign accept    = din.valid && din.ready;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (din.char_in),
    .end_of_text (din.end_of_text),
    .out_limit   (out_limit),
    .push        (push),
    .entry       (push_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (head_entry),
    .full  (full),
    .empty (empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_entry),
    .empty     (empty),
    .pop       (pop),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_kind  (dout.kind),
    .out_value (dout.value),
    .out_last  (dout.last_of_run)
  );

endmodule

/* bench/tb.sv */
// tb: self-checking bench for base64_lenient_decoder_unit.
// Drives characters and out_limit writes, predicts every result and compares.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb;

  // out_limit sits at word 0 of the register port.
  localparam logic [2:0] ADDR_OUT_LIMIT = {b64d_pkg::REG_OUT_LIMIT, 2'b00};
  // Cycles to let the decoder settle after the last result of a phase.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Random characters per out_limit setting; with the directed table the run
  // sends about 150 characters.
  localparam int unsigned CHARS_PER_PHASE = 20;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned NUM_ROWS = 23;

  // One predicted transaction on the result channel.
  typedef struct packed {
    b64d_pkg::kind_t kind;
    logic [15:0]     value;
    logic            last_of_run;
  } result_t;

  // One row of the directed table. Where typed is set, the closing status of
  // the text is written in by hand and replaces the predicted one.
  typedef struct packed {
    logic [7:0]      ch;
    logic            eot;
    logic            typed;
    b64d_pkg::kind_t kind;
    logic [15:0]     value;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b64d_in_if  char_ch ();
  b64d_out_if result_ch ();

  base64_lenient_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .din     (char_ch),
    .dout    (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Both sides throttle only while this is set.
  bit          idle_on;
  // Result mismatches, counted by the checker; register mismatches, counted
  // by the stimulus.
  int unsigned mismatch_count = 0;
  int unsigned cfg_mismatch_count;

  // Decoder shadow state, advanced once per accepted character.
  logic [15:0] shadow_limit;
  logic [17:0] group_acc;
  logic [1:0]  group_digits;
  int unsigned text_pos;
  int unsigned bytes_sent;
  logic [15:0] err_pos;
  logic [15:0] pad_pos;
  bit          stopped;

  // Results still owed by the decoder, oldest first.
  result_t pending_outputs[$];

  // Directed texts. Every status is easy to read off by hand:
  //   "TWFu"        -> "Man", three bytes
  //   "-_+/"        -> URL-safe and standard 62/63 mixed, three bytes
  //   A 0xFF = * B  -> illegal, then '=', then a later illegal that drops the
  //                    pending pad; the latest illegal position (4) wins
  //   Q Q = A       -> '=' followed by a digit: error at the '=' (3)
  //   Q Q = sp =    -> trailing pad and space, two-digit partial group: 1 byte
  //   0x00          -> text of nothing but a control character: zero bytes
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{"T",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"W",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"F",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"u",   1'b1, 1'b1, b64d_pkg::KIND_COUNT, 16'd3},
    '{"-",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"_",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"+",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"/",   1'b1, 1'b1, b64d_pkg::KIND_COUNT, 16'd3},
    '{"A",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{8'hFF, 1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"=",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"*",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"B",   1'b1, 1'b1, b64d_pkg::KIND_ERROR, 16'd4},
    '{"Q",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"Q",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"=",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"A",   1'b1, 1'b1, b64d_pkg::KIND_ERROR, 16'd3},
    '{"Q",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"Q",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"=",   1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{8'h20, 1'b0, 1'b0, b64d_pkg::KIND_BYTE,  16'd0},
    '{"=",   1'b1, 1'b1, b64d_pkg::KIND_COUNT, 16'd1},
    '{8'h00, 1'b1, 1'b1, b64d_pkg::KIND_COUNT, 16'd0}
  };

  // --------------------------------------------------------------------------
  // Decode prediction
  // --------------------------------------------------------------------------

  // Sextet of a character under both alphabets, or CODE_SKIP / CODE_BAD.
  function automatic logic [7:0] classify_char(input logic [7:0] c);
    if (c <= 8'd32) return b64d_pkg::CODE_SKIP;
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    if (c == "+" || c == "-") return 8'd62;
    if (c == "/" || c == "_") return 8'd63;
    return b64d_pkg::CODE_BAD;
  endfunction

  // Queue one decoded byte unless the text has used up out_limit.
  function automatic void push_byte(input logic [7:0] b);
    if (bytes_sent < shadow_limit) begin
      bytes_sent++;
      pending_outputs.push_back('{b64d_pkg::KIND_BYTE, {8'd0, b}, 1'b0});
    end
  endfunction

  function automatic void clear_text();
    group_acc    = '0;
    group_digits = '0;
    text_pos     = 0;
    bytes_sent   = 0;
    err_pos      = '0;
    pad_pos      = '0;
    stopped      = 1'b0;
  endfunction

  // Advance the shadow decoder by one character and queue what it causes.
  function automatic void decode_char(input logic [7:0] c, input logic eot);
    logic [7:0]  d;
    logic [23:0] word;
    int unsigned first;
    first = pending_outputs.size();
    // Position saturates; errors past the end report the top position.
    if (text_pos < b64d_pkg::MAX_TEXT_LEN && text_pos < 65535) text_pos++;
    // Limit reached: stop decoding, keep counting characters.
    if (bytes_sent >= shadow_limit) stopped = 1'b1;
    if (!stopped) begin
      d = classify_char(c);
      if (c == b64d_pkg::CHAR_PAD) begin
        pad_pos = text_pos[15:0];
      end else if (d == b64d_pkg::CODE_BAD) begin
        // An illegal character drops any pending pad.
        err_pos = text_pos[15:0];
        pad_pos = '0;
      end else if (d != b64d_pkg::CODE_SKIP) begin
        // A digit after '=' turns the '=' into the error.
        if (pad_pos != 0) begin
          err_pos = pad_pos;
          pad_pos = '0;
        end
        if (group_digits == 2'd3) begin
          word         = {group_acc, d[5:0]};
          group_acc    = '0;
          group_digits = '0;
          push_byte(word[23:16]);
          push_byte(word[15:8]);
          push_byte(word[7:0]);
          // Halt once the group holding an error is out, or at the limit.
          if (err_pos != 0 || bytes_sent >= shadow_limit) stopped = 1'b1;
        end else begin
          group_acc    = {group_acc[11:0], d[5:0]};
          group_digits = group_digits + 2'd1;
        end
      end
    end
    if (eot) begin
      // Flush a partial group: one or two digits give one byte, three give two.
      if (!stopped && group_digits != 0) begin
        word = {group_acc, 6'd0} << (6 * (3 - group_digits));
        push_byte(word[23:16]);
        if (group_digits == 2'd3) push_byte(word[15:8]);
      end
      if (err_pos != 0)
        pending_outputs.push_back('{b64d_pkg::KIND_ERROR, err_pos, 1'b0});
      else
        pending_outputs.push_back('{b64d_pkg::KIND_COUNT, bytes_sent[15:0], 1'b0});
      clear_text();
    end
    if (pending_outputs.size() > first)
      pending_outputs[pending_outputs.size() - 1].last_of_run = 1'b1;
  endfunction

  // Character for a sextet, with either spelling of 62 and 63.
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic url_safe);
    if (d < 26) return "A" + d;
    if (d < 52) return "a" + d - 8'd26;
    if (d < 62) return "0" + d - 8'd52;
    if (d == 6'd62) return url_safe ? "-" : "+";
    return url_safe ? "_" : "/";
  endfunction

  // --------------------------------------------------------------------------
  // Clock, result sink and checking
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Throttle the result side; hold ready low through reset.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 33);
    end
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: kind %0d, value %0d, last_of_run %0b",
               result_ch.kind, result_ch.value, result_ch.last_of_run);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (result_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
          mismatch_count++;
        end
        if (result_ch.value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, result_ch.value);
          mismatch_count++;
        end
        if (result_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 want.last_of_run, result_ch.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one character, idling at random first, and predict once it is taken.
  // valid stays high on return so back-to-back characters never drop it.
  task automatic send_char(input logic [7:0] c, input logic eot,
                           input logic typed = 1'b0,
                           input b64d_pkg::kind_t kind = b64d_pkg::KIND_BYTE,
                           input logic [15:0] value = '0);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 33) begin
        char_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    char_ch.valid       <= 1'b1;
    char_ch.char_in     <= c;
    char_ch.end_of_text <= eot;
    do @(posedge clk); while (!char_ch.ready);
    decode_char(c, eot);
    // Hand-typed status overrides the predicted one.
    if (typed) begin
      pending_outputs[pending_outputs.size() - 1].kind  = kind;
      pending_outputs[pending_outputs.size() - 1].value = value;
    end
  endtask

  // Drop valid and wait until every predicted result is out, then settle.
  task automatic drain(input int unsigned settle);
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Read out_limit back and compare it with what was written.
  task automatic check_out_limit(input logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_OUT_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== want) begin
      $error("out_limit: expected %0d, actual %0d", want, prdata[15:0]);
      cfg_mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write out_limit (setup then access), then read it back.
  task automatic write_out_limit(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_OUT_LIMIT;
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    shadow_limit = v;
    check_out_limit(v);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0]  text_chars[$];
    logic [7:0]  c;
    logic [15:0] phase_limit;
    int unsigned len;
    int unsigned r;
    int unsigned phase_chars;
    bit          clean;
    bit          paused;

    // Hold every input at a known value from time zero.
    rst                 = 1'b1;
    idle_on             = 1'b1;
    cfg_mismatch_count  = 0;
    paused              = 1'b0;
    char_ch.valid       = 1'b0;
    char_ch.char_in     = '0;
    char_ch.end_of_text = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    shadow_limit        = b64d_pkg::OUT_LIMIT_RESET;
    clear_text();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out_limit comes out of reset at its maximum.
    check_out_limit(b64d_pkg::OUT_LIMIT_RESET);

    // Walk the directed table.
    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].kind, directed_rows[i].value);

    // Random texts, one out_limit setting per phase. The limit is rewritten
    // only after the decoder has drained.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          phase_limit = 16'd1;
        end
        1: begin
          phase_limit = 16'd2;
        end
        2: begin
          phase_limit = 16'($urandom_range(3, 10));
        end
        3: begin
          phase_limit = 16'hFFFF;
        end
        4: begin
          phase_limit = 16'($urandom_range(1, 65535));
        end
        default: begin
          phase_limit = 16'd5;
        end
      endcase
      drain(SETTLE_CYCLES);
      write_out_limit(phase_limit);
      // Run one phase with no throttling on either side.
      idle_on = (phase != 3);

      phase_chars = 0;
      while (phase_chars < CHARS_PER_PHASE) begin
        // Mostly clean digit runs with optional padding; the rest mixes in
        // whitespace, stray '=' and arbitrary bytes.
        text_chars.delete();
        clean = ($urandom_range(0, 9) < 7);
        len   = $urandom_range(1, 12);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (clean || r < 80)
            c = digit_char(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          else if (r < 87) c = 8'($urandom_range(0, 32));
          else if (r < 92) c = b64d_pkg::CHAR_PAD;
          else c = 8'($urandom_range(0, 255));
          text_chars.push_back(c);
        end
        if (clean && $urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) text_chars.push_back(b64d_pkg::CHAR_PAD);
        if ($urandom_range(0, 4) == 0) text_chars.push_back(8'($urandom_range(0, 32)));

        foreach (text_chars[j]) begin
          // Once, mid-text: hold the sender until every result is out.
          if (phase == 2 && j == 2 && !paused) begin
            drain(0);
            paused = 1'b1;
          end
          send_char(text_chars[j], j == text_chars.size() - 1);
        end
        phase_chars += text_chars.size();
      end
    end

    // Wait for the tail and give the pipeline time to show any stray result.
    idle_on = 1'b1;
    drain(SETTLE_CYCLES);
    if (mismatch_count == 0 && cfg_mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
